// ===== hw/rtl/llrp_pkg.sv =====
`default_nettype none

package llrp_pkg;

    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 3;
    localparam int MASK_W  = 8;
    localparam int LOAD_W  = 8;
    localparam int NSLOT_W = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_PICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    localparam logic REG_NUM_SLOTS   = 1'b0;
    localparam logic REG_ENABLE_MASK = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/least_loaded_rotating_picker.sv =====
// Least-loaded rotating picker.
// The input channel (in_valid, in_stall) carries one word per command: a pick request
// with its authorized, throttled and exclude masks, or a job start or finish on a slot.
// Every command gives exactly one word on the output channel (out_valid, out_stall);
// only a pick that finds an eligible slot reports picked_valid high, else all fields zero.
// The user must write num_slots and enable_mask over the APB port only while the block
// is idle; the block itself does not enforce this. A pick reads one counter per cycle
// from the counter memory and runs it through a single compare unit; n is the slot
// count (num_slots capped at SLOTS and at 15), and the scan state covers n slots before
// the result passes through the done state into the output register. A start or finish
// is a read-modify-write through a read state and a write state; a pick on an empty
// pool or an unknown command goes straight to the done state. The block holds in_stall
// high from acceptance until its result is in the output register.
// The output register lets a new word be accepted while the last result waits.
// If the receiver stalls, the result stays in the output register unchanged, and a
// finished next result waits in the sequencer until the register frees up.
// Reset clears all job counters (through per-slot valid bits), the rotation pointer,
// num_slots to zero and enable_mask to all ones; no clearing pass is needed.
`default_nettype none

module least_loaded_rotating_picker #(
    parameter int SLOTS      = 8,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [llrp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [llrp_pkg::PDATA_W-1:0]  pwdata,
    output logic      [llrp_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [llrp_pkg::CMD_W-1:0]    cmd,
    input  wire logic [llrp_pkg::SLOT_W-1:0]   slot,
    input  wire logic [llrp_pkg::MASK_W-1:0]   authorized_mask,
    input  wire logic [llrp_pkg::MASK_W-1:0]   throttled_mask,
    input  wire logic [llrp_pkg::MASK_W-1:0]   exclude_mask,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               picked_valid,
    output logic      [llrp_pkg::SLOT_W-1:0]   picked_slot,
    output logic      [llrp_pkg::LOAD_W-1:0]   picked_load
);
    import llrp_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NCAP = (SLOTS < 15) ? SLOTS : 15;
    localparam logic [NSLOT_W-1:0] NCAP_V = NSLOT_W'(NCAP);
    localparam logic [6:0] SLOTS_V = 7'(SLOTS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVR  = 3'd1;
    localparam logic [2:0] ST_EVW  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [NSLOT_W-1:0] num_slots_reg;
    logic [MASK_W-1:0]  enable_mask_reg;
    logic [NSLOT_W-1:0] ptr_reg, ptr_next;

    logic [COUNT_BITS-1:0] mem [SLOTS];
    logic [SLOTS-1:0]      cnt_valid_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [AW-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] cur_load;

    logic [CMD_W-1:0]      cmd_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [MASK_W-1:0]     elig_reg;
    logic [NSLOT_W-1:0]    n_reg;
    logic [NSLOT_W-1:0]    pos_reg, pos_next;
    logic [NSLOT_W-1:0]    cnt_reg, cnt_next;
    logic [NSLOT_W-1:0]    tag_reg, tag_next;
    logic                  tag_v_reg, tag_v_next;
    logic                  found_reg, found_next;
    logic [NSLOT_W-1:0]    best_slot_reg, best_slot_next;
    logic [COUNT_BITS-1:0] best_load_reg, best_load_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  res_valid_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [LOAD_W-1:0]     res_load_reg;

    logic [NSLOT_W-1:0]    n_in;
    logic [NSLOT_W-1:0]    start_pos;
    logic [NSLOT_W-1:0]    start_inc;
    logic                  accept;
    logic                  cfg_wr;
    logic                  out_free;
    logic                  slot_ok;
    logic                  tag_elig;
    logic                  mem_we;
    logic [COUNT_BITS-1:0] wr_data;
    logic [6:0]            slot_ext;
    logic [6:0]            pos_ext;
    logic [15:0]           best_load_ext;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_NUM_SLOTS:   prdata[NSLOT_W-1:0] = num_slots_reg;
            REG_ENABLE_MASK: prdata[MASK_W-1:0]  = enable_mask_reg;
            default:         prdata = '0;
        endcase
    end

    assign n_in      = (num_slots_reg > NCAP_V) ? NCAP_V : num_slots_reg;
    assign start_pos = (ptr_reg < n_in) ? ptr_reg : '0;
    assign start_inc = start_pos + 1'b1;

    assign slot_ext = {4'b0, slot_reg};
    assign pos_ext  = {3'b0, pos_reg};
    assign slot_ok  = slot_ext < SLOTS_V;
    assign rd_addr  = (state_reg == ST_SCAN) ? pos_ext[AW-1:0] : slot_ext[AW-1:0];
    assign cur_load = rd_valid_reg ? rd_data_reg : '0;

    assign tag_elig = tag_v_reg && (tag_reg < NSLOT_W'(MASK_W)) && elig_reg[tag_reg[2:0]];

    always_comb
    begin
        wr_data = cur_load;
        if (cmd_reg == CMD_START)
        begin
            if (cur_load != '1)
            begin
                wr_data = cur_load + 1'b1;
            end
        end
        else if (cur_load != '0)
        begin
            wr_data = cur_load - 1'b1;
        end
    end

    assign mem_we = (state_reg == ST_EVW) && slot_ok;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        tag_next       = tag_reg;
        tag_v_next     = 1'b0;
        found_next     = found_reg;
        best_slot_next = best_slot_reg;
        best_load_next = best_load_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    found_next     = 1'b0;
                    best_slot_next = '0;
                    best_load_next = '0;
                    pos_next       = start_pos;
                    cnt_next       = '0;
                    priority if (cmd == CMD_PICK)
                    begin
                        if (n_in == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ptr_next   = (start_inc >= n_in) ? '0 : start_inc;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (cmd == CMD_START || cmd == CMD_FINISH)
                    begin
                        state_next = ST_EVR;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_EVR:
            begin
                state_next = ST_EVW;
            end
            ST_EVW:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (tag_elig && (!found_reg || cur_load < best_load_reg))
                begin
                    found_next     = 1'b1;
                    best_slot_next = tag_reg;
                    best_load_next = cur_load;
                end
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    tag_v_next = 1'b1;
                    tag_next   = pos_reg;
                    pos_next   = (pos_reg + 1'b1 == n_reg) ? '0 : pos_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            num_slots_reg   <= '0;
            enable_mask_reg <= '1;
            ptr_reg         <= '0;
            cnt_valid_reg   <= '0;
            tag_v_reg       <= 1'b0;
            found_reg       <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            tag_v_reg     <= tag_v_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (mem_we)
            begin
                cnt_valid_reg[rd_addr] <= 1'b1;
            end
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    REG_NUM_SLOTS:   num_slots_reg   <= pwdata[NSLOT_W-1:0];
                    REG_ENABLE_MASK: enable_mask_reg <= pwdata[MASK_W-1:0];
                    default:         num_slots_reg   <= num_slots_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[rd_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cnt_valid_reg[rd_addr];
        end
    end

    assign best_load_ext = 16'(best_load_reg);

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        tag_reg       <= tag_next;
        best_slot_reg <= best_slot_next;
        best_load_reg <= best_load_next;
        if (accept)
        begin
            cmd_reg  <= cmd;
            slot_reg <= slot;
            elig_reg <= enable_mask_reg & authorized_mask & ~throttled_mask & ~exclude_mask;
            n_reg    <= n_in;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            res_valid_reg <= found_reg;
            res_slot_reg  <= found_reg ? best_slot_reg[SLOT_W-1:0] : '0;
            res_load_reg  <= found_reg ? best_load_ext[LOAD_W-1:0] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign picked_valid = res_valid_reg;
    assign picked_slot  = res_slot_reg;
    assign picked_load  = res_load_reg;

    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= n_reg && pos_reg < n_reg))
        else $error("scan position or count out of range");

    a_best_eligible: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && found_reg) |-> elig_reg[best_slot_reg[2:0]])
        else $error("chosen slot is not eligible");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !picked_valid) |-> (picked_slot == '0 && picked_load == '0))
        else $error("failed pick reports nonzero fields");

    a_pointer_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && $past(state_reg) == ST_IDLE) |-> (ptr_reg < n_reg))
        else $error("rotation pointer left outside slot count");

endmodule

`default_nettype wire
